[hw/rtl/spq_pkg.sv]
// Package for the sorted priority queue: sizes, operation and status codes,
// and the command struct between controller and datapath. No dependencies.
package spq_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IN_DATA_W  = 32;
	localparam int PRIO_W     = 16;
	localparam int COUNT_W    = $clog2(CAPACITY + 1);
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

[hw/rtl/spq_req_if.sv]
// Request channel of the sorted priority queue.
// Depends on spq_pkg.
interface spq_req_if import spq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            operation;
	logic [IN_DATA_W-1:0]       data_in;
	logic signed [PRIO_W-1:0]   priority_in;

	modport source (output valid, output operation, output data_in, output priority_in,
		input ready);
	modport sink (input valid, input operation, input data_in, input priority_in,
		output ready);
endinterface

[hw/rtl/spq_rsp_if.sv]
// Response channel of the sorted priority queue.
// Depends on spq_pkg.
interface spq_rsp_if import spq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [IN_DATA_W-1:0] data_out;
	logic [COUNT_W-1:0]   fill_count;
	logic [STATUS_W-1:0]  status;

	modport source (output valid, output data_out, output fill_count, output status,
		input ready);
	modport sink (input valid, input data_out, input fill_count, input status,
		output ready);
endinterface

[hw/rtl/sorted_priority_queue.sv]
// Sorted priority queue of CAPACITY entries (data word plus signed 16-bit priority),
// kept highest priority first; equal priorities leave in arrival order. Each request
// (push, pop, clear) yields one response carrying the popped word (zero otherwise), the
// count after the operation and a status: done, pop on empty, or push dropped because
// full. A request is captured into the operand registers and applied to the entry
// registers in the execute step, where every stored priority is compared with the new
// one at once and the array shifts in a single step; the queue takes no new request
// until the previous one has executed, and a request waits in the execute step while
// the previous response has not been taken. There is no clearing pass after reset.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl and spq_datapath.
module sorted_priority_queue import spq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	spq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (req.operation),
		.data_in     (req.data_in),
		.priority_in (req.priority_in),
		.data_out    (rsp.data_out),
		.fill_count  (rsp.fill_count),
		.status      (rsp.status)
	);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.fill_count <= COUNT_W'(CAPACITY)))
		else $error("fill count exceeds capacity");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_POP_EMPTY) |-> (rsp.data_out == '0 &&
		rsp.fill_count == '0))
		else $error("pop on empty reports data or a nonzero count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_PUSH_FULL) |-> (rsp.fill_count ==
		COUNT_W'(CAPACITY) && rsp.data_out == '0))
		else $error("dropped push while not full");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted during execution");
`endif

endmodule

[hw/rtl/spq_ctrl.sv]
// Controller of the sorted priority queue: capture/execute sequencing and
// the response valid flag. Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   exec_go;

	assign req_ready = (state_q == S_IDLE);
	// The result register must be free, or emptied in this cycle, before it is rewritten.
	assign exec_go   = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);

	assign cmd.capture = req_valid && req_ready;
	assign cmd.execute = exec_go;
	assign rsp_valid   = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (exec_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/spq_datapath.sv]
// Datapath of the sorted priority queue: operand registers, the sorted entry
// array with parallel compare and shift, and the result register. Depends on spq_pkg.
module spq_datapath import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic [OP_W-1:0]          operation,
	input  logic [IN_DATA_W-1:0]     data_in,
	input  logic signed [PRIO_W-1:0] priority_in,
	output logic [IN_DATA_W-1:0]     data_out,
	output logic [COUNT_W-1:0]       fill_count,
	output logic [STATUS_W-1:0]      status
);

	op_t                     op_q;
	logic [DATA_WIDTH-1:0]   word_q;
	logic signed [PRIO_W-1:0] prio_q;

	logic [DATA_WIDTH-1:0]    ent_data_q [CAPACITY];
	logic signed [PRIO_W-1:0] ent_prio_q [CAPACITY];
	logic [COUNT_W-1:0]       count_q;

	logic [DATA_WIDTH-1:0]    ent_data_d [CAPACITY];
	logic signed [PRIO_W-1:0] ent_prio_d [CAPACITY];
	logic [COUNT_W-1:0]       count_d;
	logic [DATA_WIDTH-1:0]    res_data_d;
	status_t                  res_status_d;

	logic [DATA_WIDTH-1:0] res_data_q;
	logic [COUNT_W-1:0]    res_count_q;
	status_t               res_status_q;

	// keep[i]: stored entry i stays in place on a push (it outranks or ties the new one).
	logic [CAPACITY-1:0] keep;
	logic                full;
	logic                empty;

	assign full  = (count_q == COUNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			keep[i] = (COUNT_W'(i) < count_q) && (ent_prio_q[i] >= prio_q);
		end
	end

	always_comb begin
		ent_data_d   = ent_data_q;
		ent_prio_d   = ent_prio_q;
		count_d      = count_q;
		res_data_d   = '0;
		res_status_d = ST_DONE;
		case (op_q)
			OP_PUSH: begin
				if (full) begin
					res_status_d = ST_PUSH_FULL;
				end else begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (!keep[i]) begin
							if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
								ent_data_d[i] = word_q;
								ent_prio_d[i] = prio_q;
							end else begin
								ent_data_d[i] = ent_data_q[(i == 0) ? 0 : i - 1];
								ent_prio_d[i] = ent_prio_q[(i == 0) ? 0 : i - 1];
							end
						end
					end
					count_d = count_q + COUNT_W'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					res_status_d = ST_POP_EMPTY;
				end else begin
					res_data_d = ent_data_q[0];
					for (int i = 0; i < CAPACITY - 1; i++) begin
						ent_data_d[i] = ent_data_q[i + 1];
						ent_prio_d[i] = ent_prio_q[i + 1];
					end
					count_d = count_q - COUNT_W'(1);
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(operation);
			word_q <= DATA_WIDTH'(data_in);
			prio_q <= priority_in;
		end
		if (cmd.execute) begin
			ent_data_q   <= ent_data_d;
			ent_prio_q   <= ent_prio_d;
			res_data_q   <= res_data_d;
			res_count_q  <= count_d;
			res_status_q <= res_status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute) begin
			count_q <= count_d;
		end
	end

	assign data_out   = IN_DATA_W'(res_data_q);
	assign fill_count = res_count_q;
	assign status     = res_status_q;

endmodule
